[sv/midi_channel_message_parser_macros.svh]
// Assertion macros shared by the MIDI parser checker.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCMP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCMP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mcmp_pkg.sv]
// Types, constants and decode functions for the MIDI channel message parser.
package mcmp_pkg;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    typedef enum logic [1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_CONTROL  = 2'd2,
        KIND_OTHER    = 2'd3
    } kind_t;

    // Upper nibbles of interest
    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_CONTROL  = 4'hB;
    localparam logic [3:0] HI_PROGRAM  = 4'hC;
    localparam logic [3:0] HI_PRESSURE = 4'hD;
    localparam logic [3:0] HI_SYSTEM   = 4'hF;

    localparam logic [7:0] REALTIME_MIN = 8'hF8;

    function automatic logic [1:0] data_count_for(input logic [7:0] status);
        logic [3:0] hi;
        hi = status[7:4];
        if (hi == HI_PROGRAM || hi == HI_PRESSURE) begin
            return 2'd1;
        end
        return 2'd2;
    endfunction

    function automatic kind_t kind_of(input logic [7:0] status, input logic [6:0] second);
        logic [3:0] hi;
        hi = status[7:4];
        if (hi == HI_NOTE_ON && second != 7'd0) begin
            return KIND_NOTE_ON;
        end
        if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON) begin
            return KIND_NOTE_OFF;
        end
        if (hi == HI_CONTROL) begin
            return KIND_CONTROL;
        end
        return KIND_OTHER;
    endfunction

endpackage

[sv/midi_channel_message_parser.sv]
// MIDI channel message parser: running-status byte assembler.
// A byte passes through the input register, then its message lands in the result register.
// Throughput: one byte per cycle while m_tready stays high. A waiting result holds the parser,
// so one more byte fits in the input register and the next one waits for m_tready.
// Reset (aresetn low, synchronous): both registers empty, running status cleared.
module midi_channel_message_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mcmp_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mcmp_pkg::M_DATA_W-1:0]   m_tdata,   // [7:0] status_byte, [14:8] first_data,
                                                       // [21:15] second_data, [23:22] zero
    output mcmp_pkg::kind_t                 m_tuser    // [1:0] message_kind
);
    import mcmp_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // parser state
    logic [7:0] rs_reg, rs_next;
    logic [1:0] held_reg, held_next;
    logic [1:0] need_reg, need_next;
    logic [6:0] hold0_reg, hold0_next;
    logic [6:0] hold1_reg, hold1_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_status_reg;
    logic [6:0] out_first_reg;
    logic [6:0] out_second_reg;
    kind_t      out_kind_reg;

    logic       advance;
    logic       emit;
    logic [1:0] held_tmp;
    logic [6:0] hold0_tmp;
    logic [6:0] hold1_tmp;
    logic [6:0] second;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        rs_next    = rs_reg;
        held_next  = held_reg;
        need_next  = need_reg;
        hold0_next = hold0_reg;
        hold1_next = hold1_reg;
        emit       = 1'b0;
        held_tmp   = held_reg;
        hold0_tmp  = hold0_reg;
        hold1_tmp  = hold1_reg;
        second     = 7'd0;
        if (advance) begin
            if (in_byte_reg >= REALTIME_MIN) begin
                // real-time byte: state untouched
            end else if (in_byte_reg[7]) begin
                if (in_byte_reg[7:4] == HI_SYSTEM) begin
                    rs_next   = 8'd0;
                    held_next = 2'd0;
                    need_next = 2'd0;
                end else begin
                    rs_next   = in_byte_reg;
                    held_next = 2'd0;
                    need_next = data_count_for(in_byte_reg);
                end
            end else if (rs_reg != 8'd0 && need_reg != 2'd0) begin
                if (held_reg < 2'd2) begin
                    if (held_reg[0]) begin
                        hold1_tmp = in_byte_reg[6:0];
                    end else begin
                        hold0_tmp = in_byte_reg[6:0];
                    end
                    held_tmp = held_reg + 2'd1;
                end
                hold0_next = hold0_tmp;
                hold1_next = hold1_tmp;
                if (held_tmp >= need_reg) begin
                    emit      = 1'b1;
                    held_next = 2'd0;
                    second    = (need_reg > 2'd1) ? hold1_tmp : 7'd0;
                end else begin
                    held_next = held_tmp;
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rs_reg        <= 8'd0;
            held_reg      <= 2'd0;
            need_reg      <= 2'd0;
            hold0_reg     <= 7'd0;
            hold1_reg     <= 7'd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            rs_reg        <= rs_next;
            held_reg      <= held_next;
            need_reg      <= need_next;
            hold0_reg     <= hold0_next;
            hold1_reg     <= hold1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (emit) begin
            out_status_reg <= rs_reg;
            out_first_reg  <= hold0_tmp;
            out_second_reg <= second;
            out_kind_reg   <= kind_of(rs_reg, second);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_second_reg, out_first_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;

endmodule

[sv/mcmp_checker.sv]
// Port-level checker for the MIDI channel message parser, bound to the top level.
`include "midi_channel_message_parser_macros.svh"

module mcmp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mcmp_pkg::S_DATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mcmp_pkg::M_DATA_W-1:0]   m_tdata,
    input mcmp_pkg::kind_t                 m_tuser
);
    import mcmp_pkg::*;

    logic [3:0] out_hi;
    logic [6:0] out_second;
    logic       in_beat;
    logic       in_status;
    logic       status_ok;
    logic       kind_named;
    logic       kind_ok;
    logic       one_byte;

    assign out_hi     = m_tdata[7:4];
    assign out_second = m_tdata[21:15];
    assign in_beat    = s_tvalid && s_tready;
    assign in_status  = in_beat && s_tdata[7];
    assign status_ok  = m_tdata[7] && out_hi != HI_SYSTEM && m_tdata[23:22] == 2'b00;
    assign kind_named = m_tuser == KIND_NOTE_ON || m_tuser == KIND_CONTROL;
    assign kind_ok    = (m_tuser == KIND_NOTE_ON && out_hi == HI_NOTE_ON && out_second != 7'd0)
                     || (m_tuser == KIND_CONTROL && out_hi == HI_CONTROL);
    assign one_byte   = out_hi == HI_PROGRAM || out_hi == HI_PRESSURE;

    `MCMP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")
    `MCMP_ASSERT_NOW(a_channel_status, aclk, aresetn, m_tvalid, status_ok,
        "result status is not a channel status")
    `MCMP_ASSERT_NOW(a_kind_match, aclk, aresetn, m_tvalid && kind_named, kind_ok,
        "message kind disagrees with status")
    `MCMP_ASSERT_NOW(a_one_byte_msg, aclk, aresetn, m_tvalid && one_byte,
        out_second == 7'd0 && m_tuser == KIND_OTHER, "one-byte message carries a second byte")
    // a status byte moves on from the input register without leaving a result behind
    `MCMP_ASSERT_NEXT(a_no_result_from_status, aclk, aresetn, in_status ##1 s_tready,
        !m_tvalid, "status byte produced a result")

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (.*);
